// ----- src/pcmcv_pkg.sv -----
// ----------------------------------------------------------------------------
// pcmcv_pkg
// Shared types, format codes and conversion functions of the PCM sample
// format converter.
// ----------------------------------------------------------------------------
package pcmcv_pkg;

	localparam int unsigned CFG_W = 2;

	// Register indexes of the configuration port.
	localparam logic [0:0] REG_SOURCE_FORMAT = 1'b0;
	localparam logic [0:0] REG_SINK_FORMAT   = 1'b1;

	typedef enum logic [1:0] {
		SRC_U8  = 2'd0,
		SRC_S16 = 2'd1,
		SRC_S32 = 2'd2,
		SRC_F32 = 2'd3
	} src_fmt_t;

	typedef enum logic [1:0] {
		SNK_S16   = 2'd0,
		SNK_S24_4 = 2'd1,
		SNK_S32   = 2'd2,
		SNK_F32   = 2'd3
	} snk_fmt_t;

	// Float input to Q1.31, truncating towards zero before the sign is applied.
	function automatic logic [31:0] float_to_q31(input logic [31:0] u);
		logic        sgn;
		logic [7:0]  e;
		logic [31:0] mant;
		logic [31:0] q;
		logic [7:0]  sh;
		sgn  = u[31];
		e    = u[30:23];
		mant = {8'd0, 1'b1, u[22:0]};
		q    = '0;
		sh   = '0;
		if (e >= 8'd127) begin
			q = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			if (e >= 8'd119) begin
				sh = e - 8'd119;
				q  = mant << sh[2:0];
			end else begin
				sh = 8'd119 - e;
				q  = (sh < 8'd32) ? (mant >> sh[4:0]) : 32'd0;
			end
			if (sgn) begin
				q = 32'd0 - q;
			end
		end
		return q;
	endfunction

	// Signed Q1.31 to float scaled by 2^-31, round to nearest even.
	function automatic logic [31:0] q31_to_float(input logic [31:0] v);
		logic        sgn;
		logic [31:0] mag;
		logic [4:0]  msb;
		logic [31:0] norm;
		logic [23:0] sig;
		logic        guard;
		logic        sticky;
		logic [24:0] rsig;
		logic [7:0]  ex;
		sgn  = v[31];
		mag  = sgn ? (32'd0 - v) : v;
		msb  = '0;
		for (int i = 0; i < 32; i++) begin
			if (mag[i]) begin
				msb = 5'(i);
			end
		end
		norm   = mag << (5'd31 - msb);
		sig    = norm[31:8];
		guard  = norm[7];
		sticky = |norm[6:0];
		rsig   = {1'b0, sig} + 25'(guard & (sticky | sig[0]));
		ex     = 8'd96 + {3'd0, msb};
		if (rsig[24]) begin
			ex   = ex + 8'd1;
			rsig = rsig >> 1;
		end
		if (mag == 32'd0) begin
			return 32'd0;
		end
		return {sgn, ex, rsig[22:0]};
	endfunction

endpackage

// ----- src/pcmcv_core.sv -----
// ----------------------------------------------------------------------------
// pcmcv_core
// Combinational conversion of one sample: source to Q1.31, then to sink.
// ----------------------------------------------------------------------------
module pcmcv_core
	import pcmcv_pkg::*;
(
	input  logic [31:0] sample_bits,
	input  src_fmt_t    src_fmt,
	input  snk_fmt_t    snk_fmt,
	output logic [31:0] result
);

	logic [31:0] q31;

	// Bring the source sample to Q1.31.
	always_comb begin
		unique case (src_fmt)
			SRC_U8:  q31 = {sample_bits[7:0] - 8'h80, 24'd0};
			SRC_S16: q31 = {sample_bits[15:0], 16'd0};
			SRC_S32: q31 = sample_bits;
			SRC_F32: q31 = float_to_q31(sample_bits);
			default: q31 = sample_bits;
		endcase
	end

	// Emit in the sink encoding.
	always_comb begin
		unique case (snk_fmt)
			SNK_S16:   result = {16'd0, q31[31:16]};
			SNK_S24_4: result = {{8{q31[31]}}, q31[31:8]};
			SNK_S32:   result = q31;
			SNK_F32:   result = q31_to_float(q31);
			default:   result = q31;
		endcase
	end

endmodule

// ----- src/pcm_sample_format_converter_top.sv -----
// An accepted beat passes the input register, then the result register.
// Throughput: one beat per cycle when not stalled; the input and result
// registers each hold a beat, so a new beat is taken while a result waits.
// Reset: arst_n clears valid flags and sets both formats to signed 32-bit.
// ----------------------------------------------------------------------------
// pcm_sample_format_converter_top
// Streams audio samples through a two-register format conversion path.
// ----------------------------------------------------------------------------
module pcm_sample_format_converter_top
	import pcmcv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [31:0]      sample_bits,
	input  logic             last_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      out_bits,
	output logic             last_out
);

	src_fmt_t    src_fmt_q;
	snk_fmt_t    snk_fmt_q;
	logic        vld_s1;
	logic [31:0] bits_s1;
	logic        last_s1;
	logic        vld_s2;
	logic [31:0] bits_s2;
	logic        last_s2;
	logic [31:0] conv;
	logic        adv_s2;
	logic        adv_s1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= SRC_S32;
			snk_fmt_q <= SNK_S32;
		end else if (cfg_we) begin
			if (cfg_index == REG_SOURCE_FORMAT) begin
				src_fmt_q <= src_fmt_t'(cfg_data);
			end else begin
				snk_fmt_q <= snk_fmt_t'(cfg_data);
			end
		end
	end

	// Stage advance: a stage moves when it is empty or when the next one moves.
	assign adv_s2   = !vld_s2 || !out_stall;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			bits_s1 <= sample_bits;
			last_s1 <= last_in;
		end
	end

	pcmcv_core u_core (
		.sample_bits (bits_s1),
		.src_fmt     (src_fmt_q),
		.snk_fmt     (snk_fmt_q),
		.result      (conv)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			bits_s2 <= conv;
			last_s2 <= last_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_bits  = bits_s2;
	assign last_out  = last_s2;

endmodule

// ----- tb/tb_pcm_sample_format_converter_top.sv -----
// ----------------------------------------------------------------------------
// tb_pcm_sample_format_converter_top
// Self-checking bench for the PCM sample format converter. Source samples
// are streamed through every pair of source and sink formats while both
// sides idle at random. An independent conversion predictor computes each
// expected output beat, which is compared field by field as it arrives.
// ----------------------------------------------------------------------------
module tb_pcm_sample_format_converter_top;
	import pcmcv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [31:0] bits;
		logic        last;
	} sample_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [1:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] sample_bits;
	logic        last_in;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] out_bits;
	logic        last_out;

	// Conversion settings as the bench believes them to be.
	src_fmt_t src_fmt;
	snk_fmt_t snk_fmt;

	sample_beat_t converted_q[$];
	int          n_errors;
	int          n_cycles;
	bit          calm;
	int          hold_cycles;

	pcm_sample_format_converter_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_bits(sample_bits),
		.last_in    (last_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_bits   (out_bits),
		.last_out   (last_out)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog on the total run length.
	initial n_cycles = 0;
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Float sample to Q1.31: the significand is scaled by the exponent and
	// truncated towards zero, with saturation at one and above.
	function automatic logic [31:0] single_to_fixed(input logic [31:0] u);
		logic [7:0]  expo;
		logic [63:0] wide;
		logic [31:0] mag;
		expo = u[30:23];
		if (expo >= 8'd127) begin
			return u[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		wide = ({40'd0, 1'b1, u[22:0]} << 8) >> (8'd127 - expo);
		mag  = wide[31:0];
		return u[31] ? -mag : mag;
	endfunction

	// Q1.31 to single precision scaled by 2^-31, nearest even.
	function automatic logic [31:0] fixed_to_single(input logic [31:0] v);
		logic [31:0] mag;
		logic [31:0] norm;
		logic [24:0] frac;
		logic [7:0]  expo;
		int          lz;
		if (v == 32'd0) begin
			return 32'd0;
		end
		mag  = v[31] ? -v : v;
		lz   = 0;
		norm = mag;
		while (!norm[31]) begin
			norm = norm << 1;
			lz++;
		end
		expo = 8'(127 - lz);
		frac = {1'b0, norm[31:8]};
		if (norm[7] && ((norm[6:0] != 7'd0) || norm[8])) begin
			frac = frac + 25'd1;
		end
		if (frac[24]) begin
			expo = expo + 8'd1;
			frac = frac >> 1;
		end
		return {v[31], expo, frac[22:0]};
	endfunction

	function automatic logic [31:0] convert_sample(input logic [31:0] bits,
			input src_fmt_t src, input snk_fmt_t snk);
		logic [31:0] q;
		case (src)
			SRC_U8:  q = {bits[7:0] - 8'h80, 24'd0};
			SRC_S16: q = {bits[15:0], 16'd0};
			SRC_S32: q = bits;
			default: q = single_to_fixed(bits);
		endcase
		case (snk)
			SNK_S16:   return {16'd0, q[31:16]};
			SNK_S24_4: return 32'($signed(q) >>> 8);
			SNK_S32:   return q;
			default:   return fixed_to_single(q);
		endcase
	endfunction

	// Offers one input beat after a random gap and waits for it to be taken.
	task automatic send_sample(input logic [31:0] bits, input logic last);
		int gap;
		bit taken;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sample_bits <= bits;
		last_in     <= last;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		converted_q.push_back('{convert_sample(bits, src_fmt, snk_fmt), last});
	endtask

	// Lowers the input valid and waits for every expected beat plus latency.
	task automatic drain;
		in_valid <= 1'b0;
		while (converted_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_formats(input src_fmt_t src, input snk_fmt_t snk);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_SOURCE_FORMAT;
		cfg_data  <= src;
		@(posedge clk);
		cfg_index <= REG_SINK_FORMAT;
		cfg_data  <= snk;
		@(posedge clk);
		cfg_we <= 1'b0;
		src_fmt = src;
		snk_fmt = snk;
		@(posedge clk);
	endtask

	// Output side: random stalls, an occasional long hold, then one beat.
	initial begin
		int          n;
		bit          got;
		sample_beat_t seen;
		sample_beat_t want;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else begin
				n = calm ? 0 : $urandom_range(0, 8);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				got  = out_valid;
				seen = '{out_bits, last_out};
				@(posedge clk);
			end while (!got);
			if (converted_q.size() == 0) begin
				$display("%0t: unexpected beat out_bits=%h last_out=%b",
					$time, seen.bits, seen.last);
				n_errors++;
			end else begin
				want = converted_q.pop_front();
				if (seen.bits !== want.bits) begin
					$display("%0t: out_bits expected %h actual %h",
						$time, want.bits, seen.bits);
					n_errors++;
				end
				if (seen.last !== want.last) begin
					$display("%0t: last_out expected %b actual %b",
						$time, want.last, seen.last);
					n_errors++;
				end
			end
		end
	end

	// Reset values: signed 32-bit straight through.
	task automatic test_reset_formats;
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h7FFF_FFFF, 1'b1);
		send_sample($urandom, 1'b0);
	endtask

	// Field extremes and the special cases of the U8, S16 and F32 source formats.
	task automatic test_directed;
		logic [31:0] u8_set[4]  = '{32'h0, 32'hFF, 32'h80, 32'hFFFF_FF7F};
		logic [31:0] s16_set[3] = '{32'h7FFF, 32'h8000, 32'hFFFF_0000};
		logic [31:0] f32_set[12] = '{32'h3F80_0000, 32'hBF80_0000,
			32'h7F80_0000, 32'hFFC0_0000, 32'h8000_0000, 32'h0000_0001,
			32'h3F7F_FFFF, 32'h2C00_0000, 32'h2B80_0000, 32'hBF00_0000,
			32'h3B80_0000, 32'hBF7F_FFFF};
		set_formats(SRC_U8, SNK_S16);
		foreach (u8_set[i]) send_sample(u8_set[i], 1'(i));
		set_formats(SRC_S16, SNK_S24_4);
		foreach (s16_set[i]) send_sample(s16_set[i], 1'(i));
		set_formats(SRC_F32, SNK_F32);
		foreach (f32_set[i]) send_sample(f32_set[i], 1'(i));
		set_formats(SRC_F32, SNK_S16);
		foreach (f32_set[i]) if (i < 6) send_sample(f32_set[i], 1'b1);
	endtask

	// Random samples under every pair of formats, with calm stretches.
	task automatic test_random;
		logic [31:0] bits;
		for (int c = 0; c < 16; c++) begin
			set_formats(src_fmt_t'(c[3:2]), snk_fmt_t'(c[1:0]));
			calm = (c % 5 == 2);
			for (int k = 0; k < 68; k++) begin
				bits = $urandom;
				if (src_fmt == SRC_F32 && $urandom_range(0, 1)) begin
					bits[30:23] = 8'($urandom_range(85, 130));
				end
				send_sample(bits, 1'($urandom_range(0, 1)));
			end
			calm = 1'b0;
		end
	endtask

	// Long output hold while input keeps coming, so the input stalls.
	task automatic test_backpressure;
		set_formats(SRC_S16, SNK_F32);
		calm = 1'b1;
		hold_cycles = 60;
		for (int k = 0; k < 20; k++) send_sample($urandom, 1'(k));
		calm = 1'b0;
		drain();
	endtask

	initial begin
		n_errors    = 0;
		calm        = 1'b0;
		hold_cycles = 0;
		src_fmt     = SRC_S32;
		snk_fmt     = SNK_S32;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_SOURCE_FORMAT;
		cfg_data    = 2'd0;
		in_valid    = 1'b0;
		sample_bits = 32'd0;
		last_in     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_formats();
		test_directed();
		test_backpressure();
		test_random();
		drain();
		repeat (10) @(posedge clk);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
